// ===== hw/rtl/saai_pkg.sv =====
`default_nettype none
package saai_pkg;

  // Field and datapath widths
  localparam int unsigned CW     = 32;  // coordinate, signed Q16.16
  localparam int unsigned DW     = 33;  // extent / plane offset
  localparam int unsigned EW     = 17;  // parallel threshold
  localparam int unsigned TW     = 17;  // t, unsigned Q1.16
  localparam int unsigned TFRAC  = 16;
  localparam int unsigned RW     = DW + TW;  // divider remainder, product
  localparam int unsigned PW     = RW - TFRAC; // rounded offset along an axis
  localparam int unsigned XW     = PW + 2;     // point coordinate for compare
  localparam int unsigned NAXIS  = 3;
  localparam int unsigned NFACE  = 6;
  localparam int unsigned DIV_STAGES = TW;
  localparam logic [EW-1:0] EPS_RESET = EW'(66);

  typedef struct packed {
    logic signed [CW-1:0] seg_start_x;
    logic signed [CW-1:0] seg_start_y;
    logic signed [CW-1:0] seg_start_z;
    logic signed [CW-1:0] seg_end_x;
    logic signed [CW-1:0] seg_end_y;
    logic signed [CW-1:0] seg_end_z;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
  } in_item_t;

  typedef struct packed {
    logic          hit;
    logic [TW-1:0] hit_t;
    logic [2:0]    hit_face;
  } out_item_t;

  // Per-item geometry carried down the pipe
  typedef struct packed {
    logic [NAXIS-1:0][CW-1:0] s;
    logic [NAXIS-1:0][CW-1:0] lo;
    logic [NAXIS-1:0][CW-1:0] hi;
    logic [NAXIS-1:0][DW-1:0] d;
  } geom_t;

  // One face lane of the long divider
  typedef struct packed {
    logic          cand;
    logic [DW-1:0] ad;
    logic [RW-1:0] rem;
    logic [TW-1:0] q;
  } lane_t;

  typedef struct packed {
    geom_t                  g;
    lane_t [NFACE-1:0]      l;
  } div_item_t;

  typedef struct packed {
    logic          cand;
    logic [TW-1:0] tq;
    logic [RW-1:0] m1;
    logic [RW-1:0] m2;
  } prod_t;

  typedef struct packed {
    geom_t             g;
    prod_t [NFACE-1:0] p;
  } mul_item_t;

  typedef struct packed {
    logic          ok;
    logic [TW-1:0] tq;
  } cand_t;

  typedef struct packed {
    cand_t [NFACE-1:0] c;
  } cmp_item_t;

  // Magnitude of a signed extent
  function automatic logic [DW-1:0] mag33(input logic [DW-1:0] v);
    mag33 = v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/segment_aabb_intersect_unit.sv =====
// Segment versus axis-aligned box intersection, one query per item.
// Input channel: in_valid / in_stall / in_item carry one segment and box in
// signed Q16.16; an item is taken on a clock edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall / out_item carry
// hit, hit_t (Q1.16) and hit_face; exactly one result per item, in order.
// cfg_wr_en / cfg_wr_data write the parallel threshold; change it only
// while no item is in flight.
// Pipeline: 21 register stages (1 setup stage, 17 divider stages producing
// one quotient bit each, multiply, point check, select/output register).
// Throughput: one item per cycle when not stalled. Each stage holds while
// the stage after it is full and stalled, so bubbles are squeezed out and
// a stall on the output reaches in_stall only once the whole pipe is
// full.
// Reset (synchronous, rst_n low) empties the pipe and sets the threshold
// to 66. While out_stall is high a valid output item holds steady.
`default_nettype none
module segment_aabb_intersect_unit
  import saai_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_item_t      in_item,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_item_t          out_item,
  input  wire logic          cfg_wr_en,
  input  wire logic [EW-1:0] cfg_wr_data
);

  localparam int unsigned NST = DIV_STAGES + 4;

  logic [EW-1:0]  eps_r;
  logic [NST-1:0] v;
  logic [NST-1:0] adv;
  div_item_t      dd [DIV_STAGES + 1];
  cmp_item_t      cmp_data;

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  // A stage loads when empty or when the next one loads
  assign adv[NST-1] = !v[NST-1] || !out_stall;
  for (genvar i = 0; i < NST - 1; i++) begin : g_adv
    assign adv[i] = !v[i] || adv[i+1];
  end
  assign in_stall = !adv[0];

  saai_prep u_prep (
    .clk(clk), .rst_n(rst_n), .adv(adv[0]), .in_valid(in_valid),
    .in_item(in_item), .eps(eps_r), .valid_r(v[0]), .data_r(dd[0])
  );

  // Long division, most significant quotient bit first
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    saai_div_stage #(.BIT(DIV_STAGES - 1 - k)) u_div (
      .clk(clk), .rst_n(rst_n), .adv(adv[k+1]), .in_valid(v[k]),
      .in_data(dd[k]), .valid_r(v[k+1]), .data_r(dd[k+1])
    );
  end

  saai_point u_point (
    .clk(clk), .rst_n(rst_n),
    .adv_mul(adv[DIV_STAGES+1]), .adv_cmp(adv[DIV_STAGES+2]),
    .in_valid(v[DIV_STAGES]), .in_data(dd[DIV_STAGES]),
    .mul_valid_r(v[DIV_STAGES+1]), .valid_r(v[DIV_STAGES+2]), .data_r(cmp_data)
  );

  saai_select u_select (
    .clk(clk), .rst_n(rst_n), .adv(adv[NST-1]), .in_valid(v[DIV_STAGES+2]),
    .in_data(cmp_data), .valid_r(v[NST-1]), .data_r(out_item)
  );

  assign out_valid = v[NST-1];

`ifndef SYNTHESIS
  // A miss carries zero t and face
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> (out_item.hit_t == '0 && out_item.hit_face == '0))
    else $error("miss result with nonzero t or face");

  // A hit has t within [0, 1] and a real face
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.hit) |->
      (out_item.hit_t <= TW'(1 << TFRAC) && out_item.hit_face <= 3'd5))
    else $error("hit result out of range");

  // With the output stage empty the pipe never holds off the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/saai_prep.sv =====
`default_nettype none
module saai_prep
  import saai_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          in_valid,
  input  wire in_item_t      in_item,
  input  wire logic [EW-1:0] eps,
  output logic               valid_r,
  output div_item_t          data_r
);

  div_item_t nxt;

  // Extents, plane offsets and divider setup for all six faces
  always_comb begin
    logic [NAXIS-1:0][CW-1:0] e;
    logic [CW-1:0] plane;
    logic [DW-1:0] num;
    logic [DW-1:0] an;
    logic [DW-1:0] ad;
    nxt = '0;
    nxt.g.s  = {in_item.seg_start_z, in_item.seg_start_y, in_item.seg_start_x};
    e        = {in_item.seg_end_z, in_item.seg_end_y, in_item.seg_end_x};
    nxt.g.lo = {in_item.box_min_z, in_item.box_min_y, in_item.box_min_x};
    nxt.g.hi = {in_item.box_max_z, in_item.box_max_y, in_item.box_max_x};
    for (int a = 0; a < NAXIS; a++) begin
      nxt.g.d[a] = {e[a][CW-1], e[a]} - {nxt.g.s[a][CW-1], nxt.g.s[a]};
    end
    for (int f = 0; f < NFACE; f++) begin
      plane = f[0] ? nxt.g.hi[f >> 1] : nxt.g.lo[f >> 1];
      num   = {plane[CW-1], plane} - {nxt.g.s[f >> 1][CW-1], nxt.g.s[f >> 1]};
      ad    = mag33(nxt.g.d[f >> 1]);
      an    = mag33(num);
      nxt.l[f].cand = (ad > DW'(eps)) &&
                      ((num == '0) || (num[DW-1] == nxt.g.d[f >> 1][DW-1])) &&
                      (an <= ad);
      nxt.l[f].ad   = ad;
      // an * 2^16 + ad / 2, rounding half up
      nxt.l[f].rem  = {1'b0, an, {TFRAC{1'b0}}} + RW'(ad[DW-1:1]);
      nxt.l[f].q    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/saai_div_stage.sv =====
`default_nettype none
module saai_div_stage
  import saai_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv,
  input  wire logic in_valid,
  input  wire div_item_t in_data,
  output logic      valid_r,
  output div_item_t data_r
);

  div_item_t nxt;

  // One quotient bit per lane: compare against the shifted divisor
  always_comb begin
    logic [RW-1:0] trial;
    nxt = in_data;
    for (int f = 0; f < NFACE; f++) begin
      trial = RW'(in_data.l[f].ad) << BIT;
      if (in_data.l[f].rem >= trial) begin
        nxt.l[f].rem    = in_data.l[f].rem - trial;
        nxt.l[f].q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/saai_point.sv =====
`default_nettype none
module saai_point
  import saai_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic adv_mul,
  input  wire logic adv_cmp,
  input  wire logic in_valid,
  input  wire div_item_t in_data,
  output logic      mul_valid_r,
  output logic      valid_r,
  output cmp_item_t data_r
);

  mul_item_t mul_nxt, mul_r;
  cmp_item_t cmp_nxt;

  // Stage 1: offsets along the two other axes, |d| * t
  always_comb begin
    int o1, o2;
    mul_nxt.g = in_data.g;
    for (int f = 0; f < NFACE; f++) begin
      o1 = ((f >> 1) == 0) ? 1 : 0;
      o2 = ((f >> 1) == 2) ? 1 : 2;
      mul_nxt.p[f].cand = in_data.l[f].cand;
      mul_nxt.p[f].tq   = in_data.l[f].q;
      mul_nxt.p[f].m1   = mag33(in_data.g.d[o1]) * in_data.l[f].q;
      mul_nxt.p[f].m2   = mag33(in_data.g.d[o2]) * in_data.l[f].q;
    end
  end

  // Stage 2: round, place the point and check the box
  always_comb begin
    int o1, o2;
    logic [RW-1:0] r1s, r2s;
    logic signed [XW-1:0] p1, p2;
    logic own, in1, in2;
    for (int f = 0; f < NFACE; f++) begin
      o1  = ((f >> 1) == 0) ? 1 : 0;
      o2  = ((f >> 1) == 2) ? 1 : 2;
      r1s = mul_r.p[f].m1 + RW'(1 << (TFRAC - 1));
      r2s = mul_r.p[f].m2 + RW'(1 << (TFRAC - 1));
      p1  = mul_r.g.d[o1][DW-1]
          ? XW'($signed(mul_r.g.s[o1])) - $signed(XW'(r1s[RW-1:TFRAC]))
          : XW'($signed(mul_r.g.s[o1])) + $signed(XW'(r1s[RW-1:TFRAC]));
      p2  = mul_r.g.d[o2][DW-1]
          ? XW'($signed(mul_r.g.s[o2])) - $signed(XW'(r2s[RW-1:TFRAC]))
          : XW'($signed(mul_r.g.s[o2])) + $signed(XW'(r2s[RW-1:TFRAC]));
      own = $signed(mul_r.g.lo[f >> 1]) <= $signed(mul_r.g.hi[f >> 1]);
      in1 = (p1 >= XW'($signed(mul_r.g.lo[o1]))) && (p1 <= XW'($signed(mul_r.g.hi[o1])));
      in2 = (p2 >= XW'($signed(mul_r.g.lo[o2]))) && (p2 <= XW'($signed(mul_r.g.hi[o2])));
      cmp_nxt.c[f].ok = mul_r.p[f].cand && own && in1 && in2;
      cmp_nxt.c[f].tq = mul_r.p[f].tq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      if (adv_mul) mul_valid_r <= in_valid;
      if (adv_cmp) valid_r     <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_mul) mul_r  <= mul_nxt;
    if (adv_cmp) data_r <= cmp_nxt;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/saai_select.sv =====
`default_nettype none
module saai_select
  import saai_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire logic      in_valid,
  input  wire cmp_item_t in_data,
  output logic           valid_r,
  output out_item_t      data_r
);

  out_item_t nxt;

  // Smallest t wins; strict compare keeps the lower face on a tie
  always_comb begin
    nxt = '0;
    for (int f = 0; f < NFACE; f++) begin
      if (in_data.c[f].ok && (!nxt.hit || (in_data.c[f].tq < nxt.hit_t))) begin
        nxt.hit      = 1'b1;
        nxt.hit_t    = in_data.c[f].tq;
        nxt.hit_face = 3'(f);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= nxt;
    end
  end

endmodule
`default_nettype wire
